// ===== sv/lbp_pkg.sv =====
// ----------------------------------------------------------------------------
// lbp_pkg
// Shared types, mode codes and the uniform-pattern rank table for the
// 3x3 local binary pattern coder.
// ----------------------------------------------------------------------------
package lbp_pkg;

    localparam int PIX_W     = 8;
    localparam int NUM_NB    = 8;
    localparam int CODE_W    = 8;
    localparam int OFFSET_W  = 9;
    localparam int THR_W     = 10;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DATA_W = 9;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_MODE  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_OFFSET = 1'd1;

    typedef enum logic [2:0] {
        MODE_UNIFORM     = 3'd0,
        MODE_PLAIN       = 3'd1,
        MODE_ROT_MIN     = 3'd2,
        MODE_ROT_MIN_UNI = 3'd3,
        MODE_ROT_MIN_THR = 3'd4
    } t_mode;

    typedef struct packed {
        logic [PIX_W-1:0] center_pixel;
        logic [PIX_W-1:0] nb_left;
        logic [PIX_W-1:0] nb_lower_left;
        logic [PIX_W-1:0] nb_below;
        logic [PIX_W-1:0] nb_lower_right;
        logic [PIX_W-1:0] nb_right;
        logic [PIX_W-1:0] nb_upper_right;
        logic [PIX_W-1:0] nb_above;
        logic [PIX_W-1:0] nb_upper_left;
    } t_item;

    typedef struct packed {
        logic [CODE_W-1:0] pattern_code;
        logic              mode_invalid;
    } t_result;

    typedef logic [255:0][CODE_W-1:0] t_rank_table;

    // Rank 1..58 for codes with at most two circular transitions, 0 otherwise
    function automatic t_rank_table build_rank_table();
        t_rank_table tbl;
        logic [CODE_W-1:0] rank;
        logic [CODE_W-1:0] c;
        logic [CODE_W-1:0] x;
        rank = 8'd1;
        for (int i = 0; i < 256; i++) begin
            c = i[CODE_W-1:0];
            x = c ^ {c[0], c[CODE_W-1:1]};
            if ($countones(x) <= 2) begin
                tbl[i] = rank;
                rank   = rank + 8'd1;
            end else begin
                tbl[i] = '0;
            end
        end
        return tbl;
    endfunction

    localparam t_rank_table UNIFORM_RANK = build_rank_table();

endpackage

// ===== sv/lbp_pattern_code.sv =====
// ----------------------------------------------------------------------------
// lbp_pattern_code
// Pipeline: a start transfer passes r_v1, r_v2 and r_done before the o_done strobe.
// Throughput: one window per cycle; o_busy stays low, the pipeline takes a
//   new window every clock and the receiver cannot stall it.
// Reset (i_rst_n low, synchronous): pipeline valids clear, pattern_mode
//   returns to plain code and center_offset to zero.
// ----------------------------------------------------------------------------
module lbp_pattern_code (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_start,
    output logic                                o_busy,
    input  lbp_pkg::t_item                      i_item,
    output logic                                o_done,
    output lbp_pkg::t_result                    o_result,
    input  logic                                i_cfg_we,
    input  logic [lbp_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [lbp_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import lbp_pkg::*;

    // Configuration registers
    logic [2:0]          r_mode;
    logic [OFFSET_W-1:0] r_offset;

    // Stage 1: raw pattern from the comparator lanes
    logic                r_v1;
    logic [CODE_W-1:0]   r_raw1;
    logic [2:0]          r_mode1;

    // Stage 2: rotation minimum alongside the raw pattern
    logic                r_v2;
    logic [CODE_W-1:0]   r_raw2;
    logic [CODE_W-1:0]   r_rot2;
    logic [2:0]          r_mode2;

    // Stage 3: output register
    logic                r_done;
    t_result             r_result;
    t_result             n_result;

    logic signed [THR_W-1:0] thr;
    logic [PIX_W-1:0]        nb [NUM_NB];
    logic [CODE_W-1:0]       raw_bits;
    logic [CODE_W-1:0]       rot_min;

    // Never stall: every window enters the pipeline on its start cycle
    assign o_busy = 1'b0;

    // Hold configuration; the user must write only while the pipeline is empty (not enforced here)
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= MODE_PLAIN;
            r_offset <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_PATTERN_MODE:  r_mode   <= i_cfg_data[2:0];
                CFG_CENTER_OFFSET: r_offset <= i_cfg_data[OFFSET_W-1:0];
                default: ;
            endcase
        end
    end

    // Threshold: center, plus the signed offset only in the thresholded mode.
    // Full 10-bit precision, so a negative threshold sets every bit and one
    // above 255 clears every bit.
    always_comb begin
        if (r_mode == MODE_ROT_MIN_THR) begin
            thr = $signed({2'b00, i_item.center_pixel})
                + $signed({r_offset[OFFSET_W-1], r_offset});
        end else begin
            thr = $signed({2'b00, i_item.center_pixel});
        end
    end

    assign nb[0] = i_item.nb_left;
    assign nb[1] = i_item.nb_lower_left;
    assign nb[2] = i_item.nb_below;
    assign nb[3] = i_item.nb_lower_right;
    assign nb[4] = i_item.nb_right;
    assign nb[5] = i_item.nb_upper_right;
    assign nb[6] = i_item.nb_above;
    assign nb[7] = i_item.nb_upper_left;

    // One comparator lane per neighbor
    for (genvar k = 0; k < NUM_NB; k++) begin : g_lane
        lbp_cmp_lane u_lane (
            .i_nb  (nb[k]),
            .i_thr (thr),
            .o_bit (raw_bits[k])
        );
    end

    // Merge the eight rotations of the registered pattern
    lbp_rot_min u_rot_min (
        .i_code (r_raw1),
        .o_min  (rot_min)
    );

    // Advance the valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v1   <= i_start && !o_busy;
            r_v2   <= r_v1;
            r_done <= r_v2;
        end
    end

    // Payload registers carry no reset
    always_ff @(posedge i_clk) begin
        r_raw1   <= raw_bits;
        r_mode1  <= r_mode;
        r_raw2   <= r_raw1;
        r_rot2   <= rot_min;
        r_mode2  <= r_mode1;
        r_result <= n_result;
    end

    // Select the final code by mode; unknown modes give zero and a flag
    always_comb begin
        n_result = '0;
        case (r_mode2)
            MODE_UNIFORM:     n_result.pattern_code = UNIFORM_RANK[r_raw2];
            MODE_PLAIN:       n_result.pattern_code = r_raw2;
            MODE_ROT_MIN:     n_result.pattern_code = r_rot2;
            MODE_ROT_MIN_UNI: n_result.pattern_code = UNIFORM_RANK[r_rot2];
            MODE_ROT_MIN_THR: n_result.pattern_code = r_rot2;
            default:          n_result.mode_invalid = 1'b1;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

    // A start transfer shows up as an o_done strobe after passing r_v1, r_v2 and r_done
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> ##3 o_done)
        else $error("start transfer did not produce a result after 3 cycles");

    // No strobe without a window in the stage before
    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_v2))
        else $error("result strobe without a window in flight");

    // The rotation minimum never exceeds the unrotated pattern
    a_rot_min_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v2 |-> (r_rot2 <= r_raw2))
        else $error("rotation minimum above raw pattern");

    // Invalid mode always reports a zero code
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.mode_invalid) |-> (o_result.pattern_code == '0))
        else $error("invalid mode produced a nonzero code");

endmodule

// ===== sv/lbp_cmp_lane.sv =====
// ----------------------------------------------------------------------------
// lbp_cmp_lane
// One neighbor comparator lane: sets the pattern bit when the neighbor is at
// least the signed threshold.
// ----------------------------------------------------------------------------
module lbp_cmp_lane (
    input  logic [lbp_pkg::PIX_W-1:0]        i_nb,
    input  logic signed [lbp_pkg::THR_W-1:0] i_thr,
    output logic                             o_bit
);
    import lbp_pkg::*;

    logic signed [THR_W-1:0] nb_ext;

    assign nb_ext = $signed({{(THR_W-PIX_W){1'b0}}, i_nb});
    assign o_bit  = (nb_ext >= i_thr);

endmodule

// ===== sv/lbp_rot_min.sv =====
// ----------------------------------------------------------------------------
// lbp_rot_min
// Eight rotation lanes of the raw pattern merged by a three-level minimum tree.
// ----------------------------------------------------------------------------
module lbp_rot_min (
    input  logic [lbp_pkg::CODE_W-1:0] i_code,
    output logic [lbp_pkg::CODE_W-1:0] o_min
);
    import lbp_pkg::*;

    logic [2*CODE_W-1:0]  dbl;
    logic [CODE_W-1:0]    rot  [NUM_NB];
    logic [CODE_W-1:0]    lvl1 [4];
    logic [CODE_W-1:0]    lvl2 [2];

    assign dbl = {i_code, i_code};

    // rotation r: bit k takes raw bit (k + r) mod 8
    for (genvar r = 0; r < NUM_NB; r++) begin : g_rot
        assign rot[r] = dbl[r +: CODE_W];
    end

    for (genvar j = 0; j < 4; j++) begin : g_l1
        assign lvl1[j] = (rot[2*j] < rot[2*j+1]) ? rot[2*j] : rot[2*j+1];
    end

    for (genvar j = 0; j < 2; j++) begin : g_l2
        assign lvl2[j] = (lvl1[2*j] < lvl1[2*j+1]) ? lvl1[2*j] : lvl1[2*j+1];
    end

    assign o_min = (lvl2[0] < lvl2[1]) ? lvl2[0] : lvl2[1];

endmodule
